### rtl/mpds_pkg.sv
package mpds_pkg;

    localparam int P_W        = 24;  // monthly precipitation
    localparam int K_W        = 5;   // wet days, day number, month length
    localparam int FRAC_W     = 17;  // daily fraction, 16 fractional bits
    localparam int OUT_W      = 30;  // daily precipitation
    localparam int DIV_W      = 29;  // dividend of the serial divider (P*N)
    localparam int MUL_W      = P_W + FRAC_W;  // first product
    localparam int FMUL_W     = MUL_W + K_W;   // fraction-mode product
    localparam int FRAC_SHIFT = 16;
    localparam int STEP_W     = 5;   // divider step count, up to DIV_W

    localparam logic MODE_WET  = 1'b0;
    localparam logic MODE_FRAC = 1'b1;

    localparam logic [K_W-1:0] K_MISSING = 5'd31;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [K_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [K_W-1:0]   rem;
    } t_div_rsp;

endpackage

### rtl/mpds_div.sv
// Restoring divider, one quotient bit per cycle. The dividend is left aligned:
// a run of S steps divides the top S bits of it.
module mpds_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpds_pkg::t_div_req i_req,
    output mpds_pkg::t_div_rsp o_rsp
);
    import mpds_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [K_W-1:0]    r_rem, n_rem;
    logic [K_W-1:0]    r_dvs, n_dvs;
    logic [K_W:0]      trial;
    logic              fits;

    always_comb begin
        trial  = {r_rem, r_quo[DIV_W-1]};
        fits   = (trial >= {1'b0, r_dvs});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.steps;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DIV_W-2:0], fits};
            n_rem = fits ? K_W'(trial - {1'b0, r_dvs}) : trial[K_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp = '{done: r_done, quot: r_quo, rem: r_rem};

endmodule

### rtl/monthly_precip_day_spreader.sv
// Monthly-to-daily precipitation spreader, one grid cell per beat.
//
// Input channel: raise start with the cell's fields; the beat is taken at the
// edge where start is high and busy is low. busy stays high until the result
// is out. Result channel: o_valid strobes for exactly one cycle with the
// daily amount, the missing flag and the wet-day flag; there is no stall.
// Configuration: one mode bit on i_cfg_data, taken whenever i_cfg_valid is
// high (o_cfg_ready is always high); write it only while busy is low.
//
// Sequence, from the accepting edge up to the o_valid strobe: fraction mode
// stops after the first multiply with a missing input and otherwise does two
// (one multiply of P by the fraction, one by N). Wet-days mode with no wet
// days stops there too; with every day wet it skips the event search and runs
// a 29-step divide of P*N by K on the serial divider. Otherwise it runs a
// 5-step divide of N by 2M, then walks the events one per cycle until one
// lands on or past the day. A dry day ends there; a wet day adds the 29-step
// divide. A new beat may start in the cycle o_valid is shown.
// Reset clears the sequencer and sets the mode to wet-days spreading.
module monthly_precip_day_spreader (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mpds_pkg::P_W-1:0]    i_precip_monthly,
    input  logic                        i_precip_missing,
    input  logic [mpds_pkg::K_W-1:0]    i_wet_days,
    input  logic                        i_wet_days_missing,
    input  logic [mpds_pkg::FRAC_W-1:0] i_day_fraction,
    input  logic                        i_fraction_missing,
    input  logic [mpds_pkg::K_W-1:0]    i_day_of_month,
    input  logic [mpds_pkg::K_W-1:0]    i_month_length,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data,
    output logic                        o_valid,
    output logic [mpds_pkg::OUT_W-1:0]  o_precip_daily,
    output logic                        o_result_missing,
    output logic                        o_is_wet_day
);
    import mpds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ESTART, S_EWAIT, S_EVT, S_ASTART, S_AWAIT, S_FMUL
    } t_state;

    t_state r_state, n_state;
    logic   r_mode, n_mode;
    logic   r_valid, n_valid;

    // latched beat
    logic [P_W-1:0]    r_p, n_p;
    logic [K_W-1:0]    r_k, n_k;
    logic [K_W-1:0]    r_n, n_n;
    logic [K_W-1:0]    r_d, n_d;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic              r_fmiss, n_fmiss;

    // event walk
    logic              r_inv, n_inv;
    logic [K_W-1:0]    r_den, n_den;
    logic [6:0]        r_q, n_q;
    logic [K_W-1:0]    r_r, n_r;
    logic [K_W-1:0]    r_sa, n_sa;
    logic [K_W-1:0]    r_sb, n_sb;
    logic [K_W-1:0]    r_e, n_e;

    // products and result
    logic [MUL_W-1:0]  r_mul, n_mul;
    logic [OUT_W-1:0]  r_amt, n_amt;
    logic              r_wet, n_wet;
    logic              r_rmiss, n_rmiss;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // scratch
    logic [K_W-1:0]    k_raw;
    logic [FRAC_W-1:0] mul_b;
    logic [K_W-1:0]    m;
    logic [K_W-1:0]    a0;
    logic [K_W:0]      b2;
    logic [K_W:0]      r2;
    logic [6:0]        rnd;
    logic [K_W:0]      rsum;
    logic [FMUL_W-1:0] fprod;
    logic              wet_pick;
    logic              decide;

    mpds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        n_mode  = i_cfg_valid ? i_cfg_data : r_mode;
        n_valid = 1'b0;
        n_p     = r_p;
        n_k     = r_k;
        n_n     = r_n;
        n_d     = r_d;
        n_frac  = r_frac;
        n_fmiss = r_fmiss;
        n_inv   = r_inv;
        n_den   = r_den;
        n_q     = r_q;
        n_r     = r_r;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_e     = r_e;
        n_mul   = r_mul;
        n_amt   = r_amt;
        n_wet   = r_wet;
        n_rmiss = r_rmiss;

        div_req.start    = 1'b0;
        div_req.steps    = STEP_W'(DIV_W);
        div_req.dividend = r_mul[DIV_W-1:0];
        div_req.divisor  = r_k;

        k_raw    = i_wet_days_missing ? K_MISSING : i_wet_days;
        mul_b    = (r_mode == MODE_FRAC) ? r_frac : FRAC_W'(r_n);
        m        = (r_k > (r_n >> 1)) ? (r_n - r_k) : r_k;
        a0       = div_rsp.quot[K_W-1:0];
        b2       = {div_rsp.rem, 1'b0};
        r2       = {r_r, 1'b0};
        rnd      = r_q;
        rsum     = {1'b0, r_r} + {1'b0, r_sb};
        fprod    = FMUL_W'(r_mul) * FMUL_W'(r_n);
        wet_pick = 1'b0;
        decide   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    // missing precipitation reads as zero when spreading
                    n_p     = (r_mode == MODE_WET && i_precip_missing) ? '0
                                                                       : i_precip_monthly;
                    n_k     = (k_raw > i_month_length) ? i_month_length : k_raw;
                    n_n     = i_month_length;
                    n_d     = i_day_of_month;
                    n_frac  = i_day_fraction;
                    n_fmiss = i_precip_missing | i_fraction_missing;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_mul = MUL_W'(r_p) * MUL_W'(mul_b);
                if (r_mode == MODE_FRAC) begin
                    if (r_fmiss) begin
                        n_amt   = '0;
                        n_rmiss = 1'b1;
                        n_wet   = 1'b0;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FMUL;
                    end
                end else if (r_k == '0) begin
                    n_amt   = '0;
                    n_rmiss = 1'b0;
                    n_wet   = 1'b0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_k == r_n) begin
                    n_wet   = 1'b1;
                    n_state = S_ASTART;
                end else begin
                    // place the dry days instead when most days are wet
                    n_inv   = (r_k > (r_n >> 1));
                    n_den   = {m[K_W-2:0], 1'b0};
                    n_state = S_ESTART;
                end
            end
            S_ESTART: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(K_W);
                div_req.dividend = {r_n, (DIV_W-K_W)'(0)};
                div_req.divisor  = r_den;
                n_state          = S_EWAIT;
            end
            S_EWAIT: begin
                if (div_rsp.done) begin
                    // N = a0*den + b0; the step 2N is 2*a0*den + 2*b0
                    if (b2 >= {1'b0, r_den}) begin
                        n_sa = {a0[K_W-2:0], 1'b1};
                        n_sb = K_W'(b2 - {1'b0, r_den});
                    end else begin
                        n_sa = {a0[K_W-2:0], 1'b0};
                        n_sb = b2[K_W-1:0];
                    end
                    n_q = 7'(a0);
                    n_r = div_rsp.rem;
                    n_e = '0;
                    if (r_d == '0) begin
                        decide   = 1'b1;
                        wet_pick = r_inv;
                    end else begin
                        n_state = S_EVT;
                    end
                end
            end
            S_EVT: begin
                // round half to even
                if (r2 > {1'b0, r_den}) begin
                    rnd = r_q + 7'd1;
                end else if (r2 == {1'b0, r_den}) begin
                    rnd = r_q + 7'(r_q[0]);
                end
                if (rnd == 7'(r_d)) begin
                    decide   = 1'b1;
                    wet_pick = !r_inv;
                end else if (r_e == r_d - 1'b1 || r_q > 7'(r_d)) begin
                    // events only move later: stop once past the day
                    decide   = 1'b1;
                    wet_pick = r_inv;
                end else begin
                    if (rsum >= {1'b0, r_den}) begin
                        n_r = K_W'(rsum - {1'b0, r_den});
                        n_q = r_q + 7'(r_sa) + 7'd1;
                    end else begin
                        n_r = rsum[K_W-1:0];
                        n_q = r_q + 7'(r_sa);
                    end
                    n_e = r_e + 1'b1;
                end
            end
            S_ASTART: begin
                div_req.start = 1'b1;
                n_state       = S_AWAIT;
            end
            S_AWAIT: begin
                if (div_rsp.done) begin
                    n_amt   = OUT_W'(div_rsp.quot);
                    n_rmiss = 1'b0;
                    n_wet   = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FMUL: begin
                // drop the 16 fraction bits; the product never exceeds 30 bits
                n_amt   = fprod[FMUL_W-1:FRAC_SHIFT];
                n_rmiss = 1'b0;
                n_wet   = 1'b0;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (decide) begin
            n_wet = wet_pick;
            if (wet_pick) begin
                n_state = S_ASTART;
            end else begin
                n_amt   = '0;
                n_rmiss = 1'b0;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_k     <= n_k;
        r_n     <= n_n;
        r_d     <= n_d;
        r_frac  <= n_frac;
        r_fmiss <= n_fmiss;
        r_inv   <= n_inv;
        r_den   <= n_den;
        r_q     <= n_q;
        r_r     <= n_r;
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_e     <= n_e;
        r_mul   <= n_mul;
        r_amt   <= n_amt;
        r_wet   <= n_wet;
        r_rmiss <= n_rmiss;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_WET;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_valid <= n_valid;
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_valid;
    assign o_precip_daily   = r_amt;
    assign o_result_missing = r_rmiss;
    assign o_is_wet_day     = r_wet;

endmodule

### rtl/mpds_chk.sv
module mpds_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [mpds_pkg::OUT_W-1:0] o_precip_daily,
    input logic                       o_result_missing,
    input logic                       o_is_wet_day
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a finished beat");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_missing_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_missing) |-> (o_precip_daily == '0 && !o_is_wet_day))
        else $error("missing result carries an amount or wet flag");

endmodule

bind monthly_precip_day_spreader mpds_chk u_mpds_chk (.*);
